FILE: hw/rtl/zesc_pkg.sv
package zesc_pkg;

   localparam int CMD_FIFO_DEPTH = 2;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] CMD_BYTE      = 3'd0;
   localparam logic [KIND_W-1:0] CMD_ZERO_PAIR = 3'd1;
   localparam logic [KIND_W-1:0] CMD_TERM      = 3'd2;
   localparam logic [KIND_W-1:0] CMD_REC_END   = 3'd3;
   localparam logic [KIND_W-1:0] CMD_ESC_ERR   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       record_end;
      logic       escape_error;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data_byte;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } cmd_push_type;

endpackage

FILE: hw/rtl/zesc_front.sv
module zesc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  cmd_full,
   input  zesc_pkg::req_type     req_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   output zesc_pkg::cmd_push_type cmd_out
);

   logic decode_mode_ff, decode_mode_in;
   logic pending_zero_ff, pending_zero_in;
   logic accept;

   assign accept = req_push && !cmd_full;

   always_comb begin
      decode_mode_in     = decode_mode_ff;
      pending_zero_in    = pending_zero_ff;
      cmd_out.push       = 1'b0;
      cmd_out.cmd.kind   = zesc_pkg::CMD_BYTE;
      cmd_out.cmd.data_byte = req_data.data_byte;
      if (!decode_mode_ff) begin
         if (req_data.end_of_source) begin
            cmd_out.cmd.kind = zesc_pkg::CMD_TERM;
         end else if (req_data.data_byte == zesc_pkg::BYTE_ZERO) begin
            cmd_out.cmd.kind = zesc_pkg::CMD_ZERO_PAIR;
         end
         cmd_out.push = accept;
      end else if (!pending_zero_ff) begin
         // A zero is held back until the byte after it tells what it was.
         if (req_data.data_byte == zesc_pkg::BYTE_ZERO) begin
            pending_zero_in = pending_zero_ff || accept;
         end else begin
            cmd_out.push = accept;
         end
      end else begin
         if (req_data.data_byte == zesc_pkg::BYTE_ONE) begin
            cmd_out.cmd.data_byte = zesc_pkg::BYTE_ZERO;
         end else if (req_data.data_byte == zesc_pkg::BYTE_ZERO) begin
            cmd_out.cmd.kind = zesc_pkg::CMD_REC_END;
         end else begin
            cmd_out.cmd.kind = zesc_pkg::CMD_ESC_ERR;
         end
         cmd_out.push = accept;
         if (accept) begin
            pending_zero_in = 1'b0;
         end
      end
      if (csr_write_enable) begin
         decode_mode_in  = csr_write_data;
         pending_zero_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff  <= 1'b0;
         pending_zero_ff <= 1'b0;
      end else begin
         decode_mode_ff  <= decode_mode_in;
         pending_zero_ff <= pending_zero_in;
      end
   end

endmodule

FILE: hw/rtl/zesc_cmd_fifo.sv
module zesc_cmd_fifo #(
   parameter int DEPTH = zesc_pkg::CMD_FIFO_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  zesc_pkg::cmd_push_type wr,
   input  logic                   rd_pop,
   output zesc_pkg::cmd_type      rd_cmd,
   output logic                   rd_valid,
   output logic                   full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   zesc_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = entry_ff[rd_ptr_ff];
   assign do_wr    = wr.push && !full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_rd ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr.cmd;
      end
   end

endmodule

FILE: hw/rtl/zesc_back.sv
module zesc_back (
   input  logic              clock,
   input  logic              reset,
   input  zesc_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   output zesc_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   zesc_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic half_ff, half_in;
   logic slot_free;
   logic two_byte;
   logic [7:0] second_byte;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      half_in      = half_ff;
      cmd_pop      = 1'b0;
      two_byte     = 1'b0;
      second_byte  = zesc_pkg::BYTE_ZERO;
      unique case (cmd.kind)
         zesc_pkg::CMD_ZERO_PAIR: begin
            two_byte    = 1'b1;
            second_byte = zesc_pkg::BYTE_ONE;
         end
         zesc_pkg::CMD_TERM: begin
            two_byte = 1'b1;
         end
         default: begin
            two_byte = 1'b0;
         end
      endcase
      if (cmd_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (two_byte && !half_ff) begin
            // First byte of an expanded pair; the command stays queued.
            rsp_in.out_byte   = zesc_pkg::BYTE_ZERO;
            rsp_in.byte_valid = 1'b1;
            half_in           = 1'b1;
         end else begin
            cmd_pop         = 1'b1;
            half_in         = 1'b0;
            rsp_in.run_last = 1'b1;
            unique case (cmd.kind) inside
               zesc_pkg::CMD_BYTE: begin
                  rsp_in.out_byte   = cmd.data_byte;
                  rsp_in.byte_valid = 1'b1;
               end
               zesc_pkg::CMD_ZERO_PAIR, zesc_pkg::CMD_TERM: begin
                  rsp_in.out_byte   = second_byte;
                  rsp_in.byte_valid = 1'b1;
               end
               zesc_pkg::CMD_REC_END: begin
                  rsp_in.record_end = 1'b1;
               end
               zesc_pkg::CMD_ESC_ERR: begin
                  rsp_in.escape_error = 1'b1;
               end
               default: begin
                  rsp_in.out_byte = zesc_pkg::BYTE_ZERO;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hw/rtl/zero_escape_byte_stuffing_codec_unit.sv
// Zero-escape byte-stuffing codec for order-preserving record keys.
// Input channel: the source writes req_data while req_full is low and raises
// req_push; each such cycle moves one transaction. Result channel: while
// rsp_empty is low the oldest result sits on rsp_data and rsp_pop takes it.
// csr_write_enable with csr_write_data selects encode (0) or decode (1) and
// drops a half-read escape; write it only while the codec is idle.
// A front stage classifies each input and pushes at most one command into a
// short queue; a back stage expands commands into one or two results through
// a single output register.
// The first result of an input passes through the queue entry and then the
// output register, which it enters once the output register is free.
// Throughput: while the receiver keeps popping, the back stage emits one result
// per cycle, so an input that yields one result can be taken every cycle; one
// that yields two (a zero byte or a terminator in encode mode) holds the queue
// head until both are out. A zero byte in decode mode yields nothing.
// Reset empties the queue and the output register and selects encode mode.
// When the receiver stalls the output register holds, the queue fills, and
// req_full rises once the queue holds CMD_DEPTH commands.
module zero_escape_byte_stuffing_codec_unit #(
   parameter int CMD_DEPTH = zesc_pkg::CMD_FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  zesc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output zesc_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   zesc_pkg::cmd_push_type front_cmd;
   zesc_pkg::cmd_type      queue_cmd;
   logic                   queue_valid;
   logic                   queue_pop;

   zesc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .cmd_full         (req_full),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_out          (front_cmd)
   );

   zesc_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (front_cmd),
      .rd_pop   (queue_pop),
      .rd_cmd   (queue_cmd),
      .rd_valid (queue_valid),
      .full     (req_full)
   );

   zesc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (queue_cmd),
      .cmd_valid (queue_valid),
      .cmd_pop   (queue_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
